// ===== rtl/core/trdd_pkg.sv =====
`timescale 1ns / 1ps

package trdd_pkg;

    // Record format codes held in the type register
    localparam logic [2:0] TYPE_NONE        = 3'd0;
    localparam logic [2:0] TYPE_OLD_LRES_A  = 3'd1;
    localparam logic [2:0] TYPE_OLD_LRES_B  = 3'd2;
    localparam logic [2:0] TYPE_TILT        = 3'd3;
    localparam logic [2:0] TYPE_TRACKER     = 3'd4;
    localparam logic [2:0] TYPE_NEW_LRES    = 3'd5;
    localparam logic [2:0] TYPE_NEW_HRES    = 3'd6;
    localparam logic [2:0] TYPE_UNUSED      = 3'd7;
    localparam logic [2:0] TYPE_RESET       = TYPE_OLD_LRES_A;

    localparam int TYPE_W      = 3;
    localparam int BYTE_W      = 7;     // stored bits of each received byte
    localparam int REC_LEN_MAX = 17;    // longest record (tracker)
    localparam int CNT_W       = 5;     // holds 0..REC_LEN_MAX
    localparam int MAX_RECORD_BYTES_DEF = 17;

    localparam int PROX_BIT_POS = 15;
    localparam logic [15:0] PROX_MASK = 16'(1) << PROX_BIT_POS;

    localparam logic [5:0]  BTN_FLOOR   = 6'o36;    // codes above this set a button
    localparam logic [15:0] PROX_X_MIN  = 16'd256;  // x below this drops proximity
    localparam logic [4:0]  PRESS_TIP   = 5'd16;    // pressure above this is a tip press
    localparam logic [6:0]  KEY_SPACE   = 7'o40;    // tracker idle key

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef logic [REC_LEN_MAX-1:0][BYTE_W-1:0] t_rec_bytes;

    // One complete record handed from front to back
    typedef struct packed {
        logic [TYPE_W-1:0] kind;
        t_rec_bytes        bytes;
    } t_rec;

    // Result beat, last field in the lowest bits
    typedef struct packed {
        logic [5:0]  pad;
        logic [15:0] sample_count;
        logic [6:0]  key_code;
        logic [6:0]  tilt_y;
        logic [6:0]  tilt_x;
        logic [4:0]  pressure;
        logic [15:0] status_word;
        logic [15:0] roll_angle;
        logic [15:0] pitch_angle;
        logic [15:0] azimuth;
        logic [15:0] pos_z;
        logic [15:0] pos_y;
        logic [15:0] pos_x;
    } t_result;

    function automatic logic [CNT_W-1:0] rec_len(input logic [TYPE_W-1:0] kind);
        logic [CNT_W-1:0] len;
        unique case (kind) inside
            TYPE_OLD_LRES_A, TYPE_OLD_LRES_B, TYPE_NEW_LRES: len = CNT_W'(5);
            TYPE_TILT:                                      len = CNT_W'(8);
            TYPE_TRACKER:                                   len = CNT_W'(17);
            TYPE_NEW_HRES:                                  len = CNT_W'(6);
            default:                                        len = '0;
        endcase
        return len;
    endfunction

endpackage

// ===== rtl/core/trdd_front.sv =====
`timescale 1ns / 1ps

module trdd_front #(
    parameter int MAX_RECORD_BYTES = trdd_pkg::MAX_RECORD_BYTES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wen,
    input  logic [trdd_pkg::TYPE_W-1:0] i_cfg_wdata,
    input  logic                        i_byte_valid,
    input  logic [7:0]                  i_byte,
    output logic                        o_byte_ready,
    input  logic                        i_q_full,
    output logic                        o_push,
    output trdd_pkg::t_rec              o_rec
);
    import trdd_pkg::*;

    localparam int STORE_D = (MAX_RECORD_BYTES < REC_LEN_MAX) ? MAX_RECORD_BYTES
                                                              : REC_LEN_MAX;
    localparam int CMP_W   = CNT_W + 1;

    logic [TYPE_W-1:0] r_type;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [BYTE_W-1:0] r_rec [STORE_D];
    t_rec_bytes        n_bytes;
    logic [CNT_W-1:0]  len, idx;
    logic              sync, restart, take, we;

    assign o_byte_ready = !i_q_full;

    always_comb begin
        len     = rec_len(r_type);
        sync    = (r_type == TYPE_NEW_LRES) ? i_byte[6] : i_byte[7];
        take    = i_byte_valid && o_byte_ready;
        we      = take && (len != '0);
        restart = sync || (r_cnt >= len)
               || ({1'b0, r_cnt} >= CMP_W'(MAX_RECORD_BYTES));
        idx     = restart ? '0 : r_cnt;
        n_cnt   = we ? idx + CNT_W'(1) : r_cnt;
        o_push  = we && (n_cnt == len);
    end

    // record store; snapshot includes the byte being written
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < STORE_D; i++) begin
            if (we && idx == CNT_W'(i)) begin
                r_rec[i] <= i_byte[BYTE_W-1:0];
            end
        end
    end

    always_comb begin
        n_bytes = '0;
        for (int i = 0; i < STORE_D; i++) begin
            n_bytes[i] = (we && idx == CNT_W'(i)) ? i_byte[BYTE_W-1:0] : r_rec[i];
        end
    end

    assign o_rec = {r_type, n_bytes};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_type <= TYPE_RESET;
            r_cnt  <= '0;
        end else begin
            if (i_cfg_wen) begin
                r_type <= i_cfg_wdata;
            end
            r_cnt <= n_cnt;
        end
    end

endmodule

// ===== rtl/core/trdd_queue.sv =====
`timescale 1ns / 1ps

module trdd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  trdd_pkg::t_rec i_data,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output trdd_pkg::t_rec o_data
);
    import trdd_pkg::*;

    t_rec               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wp, r_rp;
    logic [Q_CNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + Q_PTR_W'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + Q_PTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + Q_CNT_W'(1);
                2'b01:   r_cnt <= r_cnt - Q_CNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== rtl/core/trdd_back.sv =====
`timescale 1ns / 1ps

module trdd_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  trdd_pkg::t_rec    i_q_rec,
    output logic              o_q_pop,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output trdd_pkg::t_result o_m_tdata
);
    import trdd_pkg::*;

    t_result r_res, n_res;
    logic    r_valid;

    assign o_q_pop    = i_q_valid && (!r_valid || i_m_tready);
    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = r_res;

    // decode one record into the held fields
    always_comb begin
        t_rec_bytes  rb;
        logic [5:0]  b6;
        logic [4:0]  p;
        logic [15:0] st;
        logic [15:0] x;
        rb    = i_q_rec.bytes;
        b6    = rb[0][5:0];
        p     = rb[0][6:2];
        st    = '0;
        x     = '0;
        n_res = r_res;
        unique case (i_q_rec.kind) inside
            TYPE_OLD_LRES_A, TYPE_OLD_LRES_B: begin
                st = rb[0][6] ? PROX_MASK : '0;
                if (b6 > BTN_FLOOR) begin
                    st = st | (16'(1) << (b6[5] ? b6[4:1] : 4'd0));
                end
                x = {2'b00, rb[1], rb[2]};
                if (x < PROX_X_MIN) begin
                    st = st & ~PROX_MASK;
                end
                n_res.pos_x        = x;
                n_res.pos_y        = {2'b00, rb[3], rb[4]};
                n_res.status_word  = st;
                n_res.sample_count = r_res.sample_count + 16'd1;
            end
            TYPE_TILT: begin
                n_res.pressure     = p;
                n_res.status_word  = {15'd0, p > PRESS_TIP} | PROX_MASK;
                n_res.pos_x        = {rb[0][1:0], rb[1], rb[2]};
                n_res.pos_y        = {rb[3][1:0], rb[4], rb[5]};
                n_res.tilt_x       = rb[6];
                n_res.tilt_y       = rb[7];
                n_res.sample_count = r_res.sample_count + 16'd1;
            end
            TYPE_TRACKER: begin
                n_res.pos_x       = {rb[9][1:0], rb[3], rb[4]};
                n_res.pos_y       = {rb[9][3:2], rb[5], rb[6]};
                n_res.pos_z       = {rb[9][5:4], rb[7], rb[8]};
                n_res.azimuth     = {rb[16][1:0], rb[10], rb[11]};
                n_res.pitch_angle = {rb[16][3:2], rb[12], rb[13]};
                n_res.roll_angle  = {rb[16][5:4], rb[14], rb[15]};
                n_res.status_word = {2'b00, rb[0], rb[1]};
                if (rb[2] != KEY_SPACE) begin
                    n_res.key_code = rb[2];
                end
            end
            TYPE_NEW_LRES: begin
                n_res.status_word  = {12'd0, b6[5:2]} | PROX_MASK;
                // the two halves overlap by one bit
                n_res.pos_x        = {9'd0, rb[1]} | {3'd0, rb[2], 6'd0};
                n_res.pos_y        = {9'd0, rb[3]} | {3'd0, rb[4], 6'd0};
                n_res.sample_count = r_res.sample_count + 16'd1;
            end
            default: begin
                n_res.pos_x        = {rb[0][1:0], rb[1], rb[2]};
                n_res.pos_y        = {rb[3][1:0], rb[4], rb[5]};
                n_res.status_word  = {11'd0, p} | PROX_MASK;
                n_res.sample_count = r_res.sample_count + 16'd1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_res   <= '0;
        end else begin
            if (o_q_pop) begin
                r_res   <= n_res;
                r_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

// ===== rtl/core/tablet_record_deframe_decode.sv =====
`timescale 1ns / 1ps

// Channel   Dir  Beat             Payload
// s (byte)  in   i_s_tvalid/o_s_tready   i_s_tdata[7:0] = rx_byte
// m (rec)   out  o_m_tvalid/i_m_tready   o_m_tdata[159:0] = decoded record
// cfg       in   i_cfg_wen               i_cfg_wdata[2:0] = tablet_type
//
// One byte beat per cycle while the queue has room. A byte that closes a record
// is written into the record queue, and from there into the output register.
// A two-entry record queue sits between framing and decode; the byte side
// stalls whenever it is full, which only a held-off result can cause.
// Synchronous active-low reset: type 1, byte count and held fields zero.
// Record store contents are undefined until written.

module tablet_record_deframe_decode #(
    parameter int MAX_RECORD_BYTES = trdd_pkg::MAX_RECORD_BYTES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wen,
    input  logic [trdd_pkg::TYPE_W-1:0] i_cfg_wdata,   // tablet_type
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [7:0]                  i_s_tdata,     // rx_byte
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    // pos_x, pos_y, pos_z, azimuth, pitch_angle, roll_angle, status_word,
    // pressure, tilt_x, tilt_y, key_code, sample_count, zero pad
    output logic [159:0]                o_m_tdata
);
    import trdd_pkg::*;

    logic    q_push, q_full, q_valid, q_pop;
    t_rec    q_in, q_out;
    t_result res;

    trdd_front #(
        .MAX_RECORD_BYTES (MAX_RECORD_BYTES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wen    (i_cfg_wen),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_byte_valid (i_s_tvalid),
        .i_byte       (i_s_tdata),
        .o_byte_ready (o_s_tready),
        .i_q_full     (q_full),
        .o_push       (q_push),
        .o_rec        (q_in)
    );

    // completed records waiting for decode
    trdd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_out)
    );

    trdd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_rec    (q_out),
        .o_q_pop    (q_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (res)
    );

    assign o_m_tdata = res;

    // a record is never pushed into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("record pushed into full queue");

    // the byte side only stalls on a full queue
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> q_full)
        else $error("byte stall without full queue");

    // a decoded record always lands in the output register
    a_pop_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |=> o_m_tvalid)
        else $error("decoded record not presented");

    // no pop while a result is held and not taken
    a_pop_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |-> !q_pop)
        else $error("result overwritten while stalled");

endmodule
